FILE: hw/rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and helpers of the temporal convolution forward unit
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int MAX_KERNEL_DEF    = 8;
	localparam int MAX_IN_FRAME_DEF  = 16;
	localparam int MAX_OUT_FRAME_DEF = 16;
	localparam int STRIDE_MAX        = 8;

	localparam logic [1:0] REQ_WEIGHT = 2'd0;
	localparam logic [1:0] REQ_BIAS   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	localparam logic [1:0] CFG_KERNEL   = 2'd0;
	localparam logic [1:0] CFG_STRIDE   = 2'd1;
	localparam logic [1:0] CFG_IN_SIZE  = 2'd2;
	localparam logic [1:0] CFG_OUT_SIZE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} tcf_state_t;

	typedef struct packed {
		logic valid;
		logic first;
	} tcf_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/tcf_cell.sv
// ----------------------------------------------------------------------------
// tcf_cell
// one output channel: weight row memory, bias, multiply-accumulate, result shift
// ----------------------------------------------------------------------------
module tcf_cell import tcf_pkg::*; #(
	parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
	parameter int MAX_IN_FRAME = MAX_IN_FRAME_DEF,
	parameter int CELL_IDX     = 0,
	parameter int ROW_SPAN     = MAX_KERNEL * MAX_IN_FRAME,
	parameter int AW           = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_weight,
	input  logic                wr_bias,
	input  logic [10:0]         wr_index,
	input  logic signed [31:0]  wr_data,
	input  tcf_ctl_t            in_ctl,
	input  logic [AW-1:0]       in_addr,
	input  logic signed [15:0]  in_data,
	output tcf_ctl_t            out_ctl,
	output logic [AW-1:0]       out_addr,
	output logic signed [15:0]  out_data,
	input  logic                load,
	input  logic                shift,
	input  logic signed [31:0]  sh_in,
	output logic signed [31:0]  sh_out
);

	localparam int ACC_W = 34 + AW;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

	logic signed [15:0]      wmem [ROW_SPAN];
	logic signed [31:0]      bias_q;
	logic signed [15:0]      w_q;
	tcf_ctl_t                ctl_q;
	logic [AW-1:0]           addr_q;
	logic signed [15:0]      data_q;
	tcf_ctl_t                ctl_s2;
	logic signed [31:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [31:0]      sat_val;
	logic signed [31:0]      sh_q;
	logic [31:0]             idx32;
	logic [31:0]             base32;
	logic                    w_hit;

	assign idx32  = 32'(wr_index);
	assign base32 = 32'(CELL_IDX * ROW_SPAN);
	assign w_hit  = (idx32 >= base32) && (idx32 < base32 + 32'(ROW_SPAN));

	always_ff @(posedge clk) begin
		if (wr_weight && w_hit) begin
			wmem[AW'(idx32 - base32)] <= sat16(wr_data);
		end
		w_q <= wmem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_bias && (idx32 == 32'(CELL_IDX))) begin
			bias_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_q  <= in_ctl;
			ctl_s2 <= ctl_q;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= in_addr;
		data_q  <= in_data;
		prod_s2 <= w_q * data_q;
	end

	assign acc_base = ctl_s2.first ? ACC_W'(bias_q) : acc_q;

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_base + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		if (acc_q > SAT_MAX) begin
			sat_val = 32'sh7fffffff;
		end else if (acc_q < SAT_MIN) begin
			sat_val = 32'sh80000000;
		end else begin
			sat_val = acc_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= sat_val;
		end else if (shift) begin
			sh_q <= sh_in;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_addr = addr_q;
	assign out_data = data_q;
	assign sh_out   = sh_q;

endmodule

FILE: hw/rtl/tcf_seq.sv
// ----------------------------------------------------------------------------
// tcf_seq
// configuration, sample counters, window line store and window sequencer
// ----------------------------------------------------------------------------
module tcf_seq import tcf_pkg::*; #(
	parameter int MAX_KERNEL    = MAX_KERNEL_DEF,
	parameter int MAX_IN_FRAME  = MAX_IN_FRAME_DEF,
	parameter int MAX_OUT_FRAME = MAX_OUT_FRAME_DEF,
	parameter int ROW_SPAN      = MAX_KERNEL * MAX_IN_FRAME,
	parameter int AW            = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	input  logic               start_sequence,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               wr_weight,
	output logic               wr_bias,
	output tcf_ctl_t           head_ctl,
	output logic [AW-1:0]      head_addr,
	output logic signed [15:0] head_data,
	output logic               load,
	output logic               shift,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_channel,
	output logic [15:0]        out_frame,
	output logic               last
);

	localparam int EC_W = (MAX_IN_FRAME > 1) ? $clog2(MAX_IN_FRAME) : 1;
	localparam int FS_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int FF_W = $clog2(MAX_KERNEL + 1);
	localparam int OC_W = (MAX_OUT_FRAME > 1) ? $clog2(MAX_OUT_FRAME) : 1;
	localparam int DRAIN_LEN = MAX_OUT_FRAME + 4;
	localparam int DC_W = $clog2(DRAIN_LEN + 1);

	tcf_state_t           state_q, state_n;
	logic [3:0]           kw_raw_q, sw_raw_q;
	logic [4:0]           nin_raw_q, nout_raw_q;
	logic [EC_W-1:0]      ec_q, ec_n;
	logic [FS_W-1:0]      fs_q, fs_n, rslot_q, rslot_n;
	logic [FF_W-1:0]      ff_q, ff_n;
	logic [2:0]           sp_q, sp_n;
	logic [15:0]          ofc_q, ofc_n, frame_q;
	logic [AW-1:0]        win_wr_addr, win_rd_addr, waddr_s1;
	logic [EC_W-1:0]      e_q;
	logic [FS_W-1:0]      t_q;
	logic [OC_W-1:0]      oc_q;
	logic [DC_W-1:0]      drain_q;
	logic                 emit;
	logic                 run_end;
	logic                 accept;
	logic                 sample_acc;
	logic                 out_acc;
	logic                 out_end;
	logic signed [15:0]   win [ROW_SPAN];
	logic signed [15:0]   wdata_s1;
	tcf_ctl_t             iss_s1;
	logic [EC_W-1:0]      nin_m1;
	logic [FS_W-1:0]      kw_m1;
	logic [OC_W-1:0]      nout_m1;

	assign accept     = in_valid && !in_stall;
	assign sample_acc = accept && (req_type == REQ_SAMPLE);
	assign wr_weight  = accept && (req_type == REQ_WEIGHT);
	assign wr_bias    = accept && (req_type == REQ_BIAS);
	assign cfg_ready  = 1'b1;
	assign out_acc    = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_raw_q   <= 4'd1;
			sw_raw_q   <= 4'd1;
			nin_raw_q  <= 5'd1;
			nout_raw_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KERNEL:   kw_raw_q   <= cfg_data[3:0];
				CFG_STRIDE:   sw_raw_q   <= cfg_data[3:0];
				CFG_IN_SIZE:  nin_raw_q  <= cfg_data;
				CFG_OUT_SIZE: nout_raw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample counters and window bookkeeping
	always_comb begin
		int kw, sw, nin, nout, ec, fs, ff, sp, rs;
		kw   = (kw_raw_q == 4'd0) ? 1 :
			((int'(kw_raw_q) > MAX_KERNEL) ? MAX_KERNEL : int'(kw_raw_q));
		sw   = (sw_raw_q == 4'd0) ? 1 :
			((int'(sw_raw_q) > STRIDE_MAX) ? STRIDE_MAX : int'(sw_raw_q));
		nin  = (nin_raw_q == 5'd0) ? 1 :
			((int'(nin_raw_q) > MAX_IN_FRAME) ? MAX_IN_FRAME : int'(nin_raw_q));
		nout = (nout_raw_q == 5'd0) ? 1 :
			((int'(nout_raw_q) > MAX_OUT_FRAME) ? MAX_OUT_FRAME : int'(nout_raw_q));
		kw_m1   = FS_W'(kw - 1);
		nin_m1  = EC_W'(nin - 1);
		nout_m1 = OC_W'(nout - 1);

		ec    = start_sequence ? 0 : int'(ec_q);
		fs    = start_sequence ? 0 : int'(fs_q);
		ff    = start_sequence ? 0 : int'(ff_q);
		sp    = start_sequence ? 0 : int'(sp_q);
		ofc_n = start_sequence ? 16'd0 : ofc_q;
		if (ec >= MAX_IN_FRAME) begin
			ec = 0;
		end
		if (fs >= MAX_KERNEL) begin
			fs = 0;
		end
		win_wr_addr = AW'(fs * MAX_IN_FRAME + ec);
		rs = fs + MAX_KERNEL - kw + 1;
		if (rs >= MAX_KERNEL) begin
			rs = rs - MAX_KERNEL;
		end
		rslot_n = FS_W'(rs);
		emit = 1'b0;
		ec = ec + 1;
		if (ec >= nin) begin
			ec = 0;
			fs = (fs + 1 >= MAX_KERNEL) ? 0 : fs + 1;
			if (ff < MAX_KERNEL) begin
				ff = ff + 1;
			end
			if (ff >= kw) begin
				if (sp >= sw) begin
					sp = 0;
				end
				emit = (sp == 0);
				sp = sp + 1;
				if (sp >= sw) begin
					sp = 0;
				end
			end
		end
		ec_n = EC_W'(ec);
		fs_n = FS_W'(fs);
		ff_n = FF_W'(ff);
		sp_n = 3'(sp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q  <= '0;
			fs_q  <= '0;
			ff_q  <= '0;
			sp_q  <= '0;
			ofc_q <= '0;
		end else if (sample_acc) begin
			ec_q  <= ec_n;
			fs_q  <= fs_n;
			ff_q  <= ff_n;
			sp_q  <= sp_n;
			ofc_q <= emit ? ofc_n + 16'd1 : ofc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc && emit) begin
			frame_q <= ofc_n;
		end
	end

	// window line store
	assign win_rd_addr = AW'(int'(rslot_q) * MAX_IN_FRAME + int'(e_q));

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			win[win_wr_addr] <= sat16(value);
		end
		wdata_s1 <= win[win_rd_addr];
		waddr_s1 <= AW'(int'(t_q) * MAX_IN_FRAME + int'(e_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
		end else begin
			iss_s1.valid <= (state_q == ST_RUN);
			iss_s1.first <= (state_q == ST_RUN) && (t_q == '0) && (e_q == '0);
		end
	end

	assign head_ctl  = iss_s1;
	assign head_addr = waddr_s1;
	assign head_data = wdata_s1;

	assign run_end = (t_q == kw_m1) && (e_q == nin_m1);
	assign out_end = out_acc && (oc_q == nout_m1);

	// tap and element walk, drain wait, result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q     <= '0;
			t_q     <= '0;
			rslot_q <= '0;
			drain_q <= '0;
			oc_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					e_q     <= '0;
					t_q     <= '0;
					rslot_q <= rslot_n;
					drain_q <= DC_W'(DRAIN_LEN);
					oc_q    <= '0;
				end
				ST_RUN: begin
					if (e_q == nin_m1) begin
						e_q <= '0;
						t_q <= t_q + FS_W'(1);
						rslot_q <= (int'(rslot_q) + 1 >= MAX_KERNEL) ? '0 :
							rslot_q + FS_W'(1);
					end else begin
						e_q <= e_q + EC_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - DC_W'(1);
				end
				ST_OUT: begin
					if (out_acc) begin
						oc_q <= oc_q + OC_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (sample_acc && emit) state_n = ST_RUN;
			ST_RUN:   if (run_end) state_n = ST_DRAIN;
			ST_DRAIN: if (drain_q == '0) state_n = ST_OUT;
			ST_OUT:   if (out_end) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		load      = 1'b0;
		shift     = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_RUN:   ;
			ST_DRAIN: load = (drain_q == '0);
			ST_OUT: begin
				out_valid = 1'b1;
				shift     = out_acc;
			end
			default: ;
		endcase
	end

	assign out_channel = 4'(oc_q);
	assign out_frame   = frame_q;
	assign last        = (oc_q == nout_m1);

endmodule

FILE: hw/rtl/temporal_conv_forward_unit.sv
// ----------------------------------------------------------------------------
// temporal_conv_forward_unit
// weight, bias and sample transactions are accepted only in the idle state;
// an emitting sample starts a window walk (one tap element per cycle) over
// kernel_width*in_frame_size elements through the cell chain, a drain wait,
// then one result per output channel; input stalls until the last is taken
// reset clears control and counters; weight, bias and window stores are not cleared
// ----------------------------------------------------------------------------
module temporal_conv_forward_unit import tcf_pkg::*; #(
	parameter int MAX_KERNEL    = MAX_KERNEL_DEF,
	parameter int MAX_IN_FRAME  = MAX_IN_FRAME_DEF,
	parameter int MAX_OUT_FRAME = MAX_OUT_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [10:0]        index,
	input  logic signed [31:0] value,
	input  logic               start_sequence,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_value,
	output logic [3:0]         out_channel,
	output logic [15:0]        out_frame,
	output logic               last
);

	localparam int ROW_SPAN = MAX_KERNEL * MAX_IN_FRAME;
	localparam int AW       = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1;

	logic               wr_weight, wr_bias, load, shift;
	tcf_ctl_t           ctl_c  [MAX_OUT_FRAME+1];
	logic [AW-1:0]      addr_c [MAX_OUT_FRAME+1];
	logic signed [15:0] data_c [MAX_OUT_FRAME+1];
	logic signed [31:0] sh_c   [MAX_OUT_FRAME+1];

	tcf_seq #(
		.MAX_KERNEL    (MAX_KERNEL),
		.MAX_IN_FRAME  (MAX_IN_FRAME),
		.MAX_OUT_FRAME (MAX_OUT_FRAME)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.value          (value),
		.start_sequence (start_sequence),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.wr_weight      (wr_weight),
		.wr_bias        (wr_bias),
		.head_ctl       (ctl_c[0]),
		.head_addr      (addr_c[0]),
		.head_data      (data_c[0]),
		.load           (load),
		.shift          (shift),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_channel    (out_channel),
		.out_frame      (out_frame),
		.last           (last)
	);

	assign sh_c[MAX_OUT_FRAME] = '0;

	for (genvar i = 0; i < MAX_OUT_FRAME; i++) begin : g_cell
		tcf_cell #(
			.MAX_KERNEL   (MAX_KERNEL),
			.MAX_IN_FRAME (MAX_IN_FRAME),
			.CELL_IDX     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_weight (wr_weight),
			.wr_bias   (wr_bias),
			.wr_index  (index),
			.wr_data   (value),
			.in_ctl    (ctl_c[i]),
			.in_addr   (addr_c[i]),
			.in_data   (data_c[i]),
			.out_ctl   (ctl_c[i+1]),
			.out_addr  (addr_c[i+1]),
			.out_data  (data_c[i+1]),
			.load      (load),
			.shift     (shift),
			.sh_in     (sh_c[i+1]),
			.sh_out    (sh_c[i])
		);
	end

	assign out_value = sh_c[0];

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - temporal convolution forward unit testbench
// loads weights and biases, streams sample sequences under changing window,
// stride and frame sizes, and compares every output transaction with a
// fixed-point model of the layer kept inside the bench
// ----------------------------------------------------------------------------
module tb;
	import tcf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_SPAN     = MAX_KERNEL_DEF * MAX_IN_FRAME_DEF;
	localparam int WEIGHT_DEPTH = MAX_OUT_FRAME_DEF * ROW_SPAN;
	localparam int DRAIN_CYCLES = 250;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int HOLD_CYCLES  = 600;

	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         channel;
		logic [15:0]        frame;
		logic               last;
	} conv_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [10:0]        index;
	logic signed [31:0] value;
	logic               start_sequence;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [4:0]         cfg_data;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_value;
	logic [3:0]         out_channel;
	logic [15:0]        out_frame;
	logic               last;

	// layer model state
	logic signed [15:0] weight_mem [WEIGHT_DEPTH];
	logic signed [31:0] bias_mem [MAX_OUT_FRAME_DEF];
	logic signed [15:0] window_mem [ROW_SPAN];
	int unsigned        elem_cnt, slot_cnt, filled_cnt, phase_cnt;
	logic [15:0]        frame_cnt;
	logic [3:0]         kernel_raw, stride_raw;
	logic [4:0]         in_size_raw, out_size_raw;

	conv_result_t pending_results[$];
	int           error_count;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           cycle_count;
	logic         holding;
	event         hold_ev;

	temporal_conv_forward_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .index(index), .value(value),
		.start_sequence(start_sequence),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_value(out_value), .out_channel(out_channel),
		.out_frame(out_frame), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_reg(int unsigned raw, int unsigned hi);
		if (raw < 1) return 1;
		if (raw > hi) return hi;
		return raw;
	endfunction

	function automatic logic signed [15:0] clamp_q88(logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		if (v < -32'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic void model_sample(logic signed [31:0] v, logic st);
		int unsigned        kw, sw, nin, nout, newest, slot;
		logic signed [63:0] acc;
		conv_result_t       r;
		kw   = clamp_reg(kernel_raw, MAX_KERNEL_DEF);
		sw   = clamp_reg(stride_raw, STRIDE_MAX);
		nin  = clamp_reg(in_size_raw, MAX_IN_FRAME_DEF);
		nout = clamp_reg(out_size_raw, MAX_OUT_FRAME_DEF);
		if (st) begin
			elem_cnt = 0; slot_cnt = 0; filled_cnt = 0; phase_cnt = 0; frame_cnt = '0;
		end
		if (elem_cnt >= MAX_IN_FRAME_DEF) elem_cnt = 0;
		if (slot_cnt >= MAX_KERNEL_DEF) slot_cnt = 0;
		window_mem[slot_cnt * MAX_IN_FRAME_DEF + elem_cnt] = clamp_q88(v);
		elem_cnt++;
		if (elem_cnt < nin) return;
		elem_cnt = 0;
		newest = slot_cnt;
		slot_cnt = (slot_cnt + 1) % MAX_KERNEL_DEF;
		if (filled_cnt < MAX_KERNEL_DEF) filled_cnt++;
		if (filled_cnt < kw) return;
		if (phase_cnt >= sw) phase_cnt = 0;
		if (phase_cnt != 0) begin
			phase_cnt++;
			if (phase_cnt >= sw) phase_cnt = 0;
			return;
		end
		phase_cnt++;
		if (phase_cnt >= sw) phase_cnt = 0;
		for (int c = 0; c < nout; c++) begin
			acc = 64'(bias_mem[c]);
			for (int t = 0; t < kw; t++) begin
				slot = (newest + MAX_KERNEL_DEF - (kw - 1) + t) % MAX_KERNEL_DEF;
				for (int e = 0; e < nin; e++)
					acc += 64'(weight_mem[c * ROW_SPAN + t * MAX_IN_FRAME_DEF + e])
						* 64'(window_mem[slot * MAX_IN_FRAME_DEF + e]);
			end
			if (acc > 64'sh7fffffff) r.value = 32'sh7fffffff;
			else if (acc < -64'sh80000000) r.value = 32'sh80000000;
			else r.value = acc[31:0];
			r.channel = c[3:0];
			r.frame   = frame_cnt;
			r.last    = (c == nout - 1);
			pending_results.push_back(r);
		end
		frame_cnt++;
	endfunction

	function automatic void model_item(logic [1:0] rt, logic [10:0] ix,
		logic signed [31:0] v, logic st);
		if (rt == REQ_WEIGHT) weight_mem[ix] = clamp_q88(v);
		else if (rt == REQ_BIAS) begin
			if (ix < MAX_OUT_FRAME_DEF) bias_mem[ix] = v;
		end else if (rt == REQ_SAMPLE) model_sample(v, st);
	endfunction

	// weight entries read by the layer shapes used below
	function automatic logic weight_used(int c, int t, int e);
		return ((t < 3) && (e < 2)) || ((c < 2) && (e < 4)) || ((c == 0) && (t == 0));
	endfunction

	task automatic send_item(logic [1:0] rt, logic [10:0] ix, logic signed [31:0] v,
		logic st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= rt;
		index          <= ix;
		value          <= v;
		start_sequence <= st;
		do @(posedge clk); while (in_stall);
		model_item(rt, ix, v, st);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] ix, logic [4:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ix)
			CFG_KERNEL:   kernel_raw   = d[3:0];
			CFG_STRIDE:   stride_raw   = d[3:0];
			CFG_IN_SIZE:  in_size_raw  = d;
			CFG_OUT_SIZE: out_size_raw = d;
			default: ;
		endcase
	endtask

	task automatic set_layer(logic [4:0] kw, logic [4:0] sw, logic [4:0] nin,
		logic [4:0] nout);
		wait_idle();
		write_reg(CFG_KERNEL, kw);
		write_reg(CFG_STRIDE, sw);
		write_reg(CFG_IN_SIZE, nin);
		write_reg(CFG_OUT_SIZE, nout);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(65535) - 32768;
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			3: return $urandom_range(1) ? 32'sd32767 : -32'sd32768;
			default: return $urandom_range(1023) - 512;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got,
			cycle_count);
		error_count++;
	endtask

	// result checking
	always @(posedge clk) begin
		conv_result_t r;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 0, out_value);
			end else begin
				r = pending_results.pop_front();
				if (out_value !== r.value) report_mismatch("out_value", r.value, out_value);
				if (out_channel !== r.channel)
					report_mismatch("out_channel", r.channel, out_channel);
				if (out_frame !== r.frame) report_mismatch("out_frame", r.frame, out_frame);
				if (last !== r.last) report_mismatch("last", r.last, last);
			end
		end
	end

	// long receiver hold, counted on its own
	initial begin
		holding = 1'b0;
		forever begin
			@(hold_ev);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_load_parameters();
		int c, t, e;
		for (int i = 0; i < WEIGHT_DEPTH; i++) begin
			c = i / ROW_SPAN;
			t = (i % ROW_SPAN) / MAX_IN_FRAME_DEF;
			e = i % MAX_IN_FRAME_DEF;
			if (weight_used(c, t, e))
				send_item(REQ_WEIGHT, 11'(i), pick_value(), 1'($urandom_range(1)));
		end
		for (int i = 0; i < MAX_OUT_FRAME_DEF; i++)
			send_item(REQ_BIAS, 11'(i), pick_value(), 1'b0);
	endtask

	task automatic test_full_window();
		set_layer(5'd8, 5'd1, 5'd4, 5'd2);
		send_item(REQ_BIAS, 11'd0, 32'sh7fffffff, 1'b1);
		send_item(REQ_BIAS, 11'd1, 32'sh80000000, 1'b0);
		send_item(REQ_BIAS, 11'd20, 32'sd5, 1'b0);
		send_item(2'd3, 11'd7, 32'sd99, 1'b1);
		for (int i = 0; i < 48; i++)
			send_item(REQ_SAMPLE, 11'($urandom), i[0] ? 32'sh7fffffff : 32'sh80000000,
				i == 0);
	endtask

	task automatic test_register_extremes();
		set_layer(5'd0, 5'd0, 5'd0, 5'd0);
		send_item(REQ_SAMPLE, 11'h7ff, 32'sh7fffffff, 1'b1);
		send_item(REQ_SAMPLE, 11'h000, 32'sh80000000, 1'b0);
		send_item(REQ_SAMPLE, 11'h123, 32'sd0, 1'b0);
		send_item(REQ_SAMPLE, 11'h456, -32'sd1, 1'b1);
		send_item(REQ_WEIGHT, 11'd0, 32'sh80000000, 1'b1);
		send_item(REQ_SAMPLE, 11'd0, 32'sd256, 1'b0);
		set_layer(5'd15, 5'd15, 5'd1, 5'd1);
		for (int i = 0; i < 16; i++)
			send_item(REQ_SAMPLE, 11'($urandom), pick_value(), 1'b0);
		set_layer(5'd1, 5'd1, 5'd31, 5'd1);
		for (int i = 0; i < 32; i++)
			send_item(REQ_SAMPLE, 11'($urandom), pick_value(), i == 0);
		set_layer(5'd1, 5'd1, 5'd1, 5'd31);
		for (int i = 0; i < 8; i++)
			send_item(REQ_SAMPLE, 11'($urandom), pick_value(), 1'b0);
		set_layer(5'd2, 5'd8, 5'd2, 5'd16);
		for (int i = 0; i < 24; i++)
			send_item(REQ_SAMPLE, 11'($urandom), pick_value(), 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [1:0] rt;
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 83 : 0;
			recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 14 : 0;
			for (int ph = 0; ph < 3; ph++) begin
				set_layer(5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)),
					5'($urandom_range(1, 2)), 5'($urandom_range(1, 16)));
				for (int i = 0; i < 20; i++) begin
					case ($urandom_range(19))
						0: rt = REQ_WEIGHT;
						1: rt = REQ_BIAS;
						2: rt = 2'd3;
						default: rt = REQ_SAMPLE;
					endcase
					if (rt == REQ_BIAS)
						send_item(rt, 11'($urandom_range(31)), pick_value(),
							1'($urandom_range(1)));
					else
						send_item(rt, 11'($urandom), pick_value(),
							(i == 0) ? 1'($urandom_range(1)) : ($urandom_range(40) == 0));
				end
			end
		end
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_layer(5'd1, 5'd1, 5'd1, 5'd16);
		-> hold_ev;
		for (int i = 0; i < 40; i++)
			send_item(REQ_SAMPLE, 11'($urandom), pick_value(), i == 0);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_WEIGHT;
		index          = '0;
		value          = '0;
		start_sequence = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_KERNEL;
		cfg_data       = '0;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		cycle_count    = 0;
		elem_cnt = 0; slot_cnt = 0; filled_cnt = 0; phase_cnt = 0; frame_cnt = '0;
		kernel_raw = 4'd1; stride_raw = 4'd1; in_size_raw = 5'd1; out_size_raw = 5'd1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_parameters();
		test_full_window();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
